// ===== rtl/lot_pkg.sv =====
package lot_pkg;

    localparam int MAX_LINES   = 1024;
    localparam int LINE_BITS   = $clog2(MAX_LINES);
    localparam int COUNT_BITS  = LINE_BITS + 1;
    localparam int OFFSET_BITS = 20;

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    typedef enum logic [1:0] {
        MODE_APPEND = 2'd0,
        MODE_LOCATE = 2'd1,
        MODE_SPAN   = 2'd2,
        MODE_NEW    = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOC_CHK,
        ST_LOC_CMP,
        ST_SPAN_A,
        ST_SPAN_B
    } t_state;

endpackage

// ===== rtl/line_offset_table_core.sv =====
// Line-start table over a byte stream. Each transaction is taken when start is high and busy
// is low. Appending a byte and starting a new text finish without raising busy, so bytes can be
// streamed every cycle. A locate transaction runs a binary search over the line-start memory:
// each probe is a memory read followed by a compare, and a search makes at most
// ceil(log2(line count)) probes. A span transaction reads the start of the queried line and,
// unless it is the last line, the start of the next; a line that does not exist needs no read. The two
// reads of neighboring table entries share the single memory read port. Every result appears
// for exactly one cycle with o_valid high, in the first cycle in which busy is low again
// (the cycle right after acceptance for a line that does not exist); the receiver cannot
// stall it and must take it then.
module line_offset_table_core
    import lot_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             i_mode,
    input  logic [7:0]             i_data_byte,
    input  logic [OFFSET_BITS-1:0] i_query_offset,
    input  logic [LINE_BITS-1:0]   i_query_line,
    output logic                   o_valid,
    output logic                   o_answer_kind,
    output logic                   o_found,
    output logic [LINE_BITS-1:0]   o_line_index,
    output logic [OFFSET_BITS-1:0] o_column,
    output logic [OFFSET_BITS-1:0] o_span_start,
    output logic [OFFSET_BITS-1:0] o_span_end,
    output logic [OFFSET_BITS-1:0] o_content_end,
    output logic                   o_overflow
);

    t_state r_state, n_state;
    logic [COUNT_BITS-1:0]  r_line_count, n_line_count;
    logic [OFFSET_BITS-1:0] r_text_len, n_text_len;
    logic                   r_prev_cr, n_prev_cr;
    logic                   r_ovf, n_ovf;
    logic                   r_valid, n_valid;

    logic [LINE_BITS-1:0]   r_lo, n_lo;
    logic [LINE_BITS-1:0]   r_hi, n_hi;
    logic [LINE_BITS-1:0]   r_mid, n_mid;
    logic [OFFSET_BITS-1:0] r_lo_start, n_lo_start;
    logic [OFFSET_BITS-1:0] r_off, n_off;
    logic [LINE_BITS-1:0]   r_q, n_q;
    logic [OFFSET_BITS-1:0] r_start, n_start;
    logic                   r_crlf, n_crlf;
    logic                   r_rd_zero;

    logic                   r_kind, n_kind;
    logic                   r_found, n_found;
    logic [LINE_BITS-1:0]   r_line_index, n_line_index;
    logic [OFFSET_BITS-1:0] r_column, n_column;
    logic [OFFSET_BITS-1:0] r_span_start, n_span_start;
    logic [OFFSET_BITS-1:0] r_span_end, n_span_end;
    logic [OFFSET_BITS-1:0] r_content_end, n_content_end;
    logic                   r_ovf_out, n_ovf_out;

    logic                   ls_we, ls_re;
    logic [LINE_BITS-1:0]   ls_wa, ls_ra;
    logic [OFFSET_BITS-1:0] ls_wd, ls_rd_raw, ls_rd;
    logic                   cr_we, cr_re, cr_wd, cr_rd;
    logic [LINE_BITS-1:0]   cr_wa, cr_ra;

    logic                   accept;
    logic [LINE_BITS:0]     probe_width;
    logic [LINE_BITS-1:0]   mid;
    logic [COUNT_BITS-1:0]  last_line;
    logic [OFFSET_BITS-1:0] text_next;

    lot_ram #(.WIDTH(OFFSET_BITS), .DEPTH(MAX_LINES)) u_starts (
        .i_clk     (i_clk),
        .i_we      (ls_we),
        .i_wr_addr (ls_wa),
        .i_wr_data (ls_wd),
        .i_re      (ls_re),
        .i_rd_addr (ls_ra),
        .o_rd_data (ls_rd_raw)
    );

    lot_ram #(.WIDTH(1), .DEPTH(MAX_LINES)) u_crlf (
        .i_clk     (i_clk),
        .i_we      (cr_we),
        .i_wr_addr (cr_wa),
        .i_wr_data (cr_wd),
        .i_re      (cr_re),
        .i_rd_addr (cr_ra),
        .o_rd_data (cr_rd)
    );

    // Line 0 always starts at offset 0, so its entry is never stored.
    assign ls_rd = r_rd_zero ? '0 : ls_rd_raw;

    assign accept      = start && (r_state == ST_IDLE);
    assign busy        = (r_state != ST_IDLE);
    assign probe_width = {1'b0, r_hi} - {1'b0, r_lo} + 1'b1;
    assign mid         = r_lo + probe_width[LINE_BITS:1];
    assign last_line   = r_line_count - 1'b1;
    assign text_next   = r_text_len + 1'b1;

    always_comb begin
        n_state       = r_state;
        n_line_count  = r_line_count;
        n_text_len    = r_text_len;
        n_prev_cr     = r_prev_cr;
        n_ovf         = r_ovf;
        n_valid       = 1'b0;
        n_lo          = r_lo;
        n_hi          = r_hi;
        n_mid         = r_mid;
        n_lo_start    = r_lo_start;
        n_off         = r_off;
        n_q           = r_q;
        n_start       = r_start;
        n_crlf        = r_crlf;
        n_kind        = r_kind;
        n_found       = r_found;
        n_line_index  = r_line_index;
        n_column      = r_column;
        n_span_start  = r_span_start;
        n_span_end    = r_span_end;
        n_content_end = r_content_end;
        n_ovf_out     = r_ovf_out;
        ls_we         = 1'b0;
        ls_wa         = r_line_count[LINE_BITS-1:0];
        ls_wd         = text_next;
        ls_re         = 1'b0;
        ls_ra         = r_mid;
        cr_we         = 1'b0;
        cr_wa         = last_line[LINE_BITS-1:0];
        cr_wd         = r_prev_cr;
        cr_re         = 1'b0;
        cr_ra         = i_query_line;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (t_mode'(i_mode))
                        MODE_APPEND: begin
                            if (r_text_len == OFFSET_MAX) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_text_len = text_next;
                                n_prev_cr  = (i_data_byte == CH_CR);
                                if (i_data_byte == CH_LF) begin
                                    if (r_line_count < COUNT_BITS'(MAX_LINES)) begin
                                        ls_we        = 1'b1;
                                        cr_we        = 1'b1;
                                        n_line_count = r_line_count + 1'b1;
                                    end else begin
                                        n_ovf = 1'b1;
                                    end
                                end
                            end
                        end
                        MODE_LOCATE: begin
                            n_lo       = '0;
                            n_hi       = last_line[LINE_BITS-1:0];
                            n_lo_start = '0;
                            n_off      = i_query_offset;
                            n_state    = ST_LOC_CHK;
                        end
                        MODE_SPAN: begin
                            n_q = i_query_line;
                            if ({1'b0, i_query_line} < r_line_count) begin
                                ls_re   = 1'b1;
                                ls_ra   = i_query_line;
                                cr_re   = 1'b1;
                                n_state = ST_SPAN_A;
                            end else begin
                                n_valid       = 1'b1;
                                n_kind        = 1'b1;
                                n_found       = 1'b0;
                                n_line_index  = '0;
                                n_column      = '0;
                                n_span_start  = '0;
                                n_span_end    = '0;
                                n_content_end = '0;
                                n_ovf_out     = r_ovf;
                            end
                        end
                        MODE_NEW: begin
                            n_line_count = COUNT_BITS'(1);
                            n_text_len   = '0;
                            n_prev_cr    = 1'b0;
                            n_ovf        = 1'b0;
                        end
                    endcase
                end
            end
            ST_LOC_CHK: begin
                if (r_lo < r_hi) begin
                    ls_re   = 1'b1;
                    ls_ra   = mid;
                    n_mid   = mid;
                    n_state = ST_LOC_CMP;
                end else begin
                    n_valid       = 1'b1;
                    n_kind        = 1'b0;
                    n_found       = 1'b1;
                    n_line_index  = r_lo;
                    n_column      = r_off - r_lo_start;
                    n_span_start  = '0;
                    n_span_end    = '0;
                    n_content_end = '0;
                    n_ovf_out     = r_ovf;
                    n_state       = ST_IDLE;
                end
            end
            ST_LOC_CMP: begin
                if (ls_rd <= r_off) begin
                    n_lo       = r_mid;
                    n_lo_start = ls_rd;
                end else begin
                    n_hi = r_mid - 1'b1;
                end
                n_state = ST_LOC_CHK;
            end
            ST_SPAN_A: begin
                n_start = ls_rd;
                n_crlf  = cr_rd;
                if ({1'b0, r_q} == last_line) begin
                    n_valid       = 1'b1;
                    n_kind        = 1'b1;
                    n_found       = 1'b1;
                    n_line_index  = '0;
                    n_column      = '0;
                    n_span_start  = ls_rd;
                    n_span_end    = r_text_len;
                    n_content_end = r_text_len;
                    n_ovf_out     = r_ovf;
                    n_state       = ST_IDLE;
                end else begin
                    ls_re   = 1'b1;
                    ls_ra   = r_q + 1'b1;
                    n_state = ST_SPAN_B;
                end
            end
            ST_SPAN_B: begin
                n_valid       = 1'b1;
                n_kind        = 1'b1;
                n_found       = 1'b1;
                n_line_index  = '0;
                n_column      = '0;
                n_span_start  = r_start;
                n_span_end    = ls_rd;
                n_content_end = ls_rd - {{(OFFSET_BITS-2){1'b0}}, r_crlf, !r_crlf};
                n_ovf_out     = r_ovf;
                n_state       = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_line_count <= COUNT_BITS'(1);
            r_text_len   <= '0;
            r_prev_cr    <= 1'b0;
            r_ovf        <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_line_count <= n_line_count;
            r_text_len   <= n_text_len;
            r_prev_cr    <= n_prev_cr;
            r_ovf        <= n_ovf;
            r_valid      <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo          <= n_lo;
        r_hi          <= n_hi;
        r_mid         <= n_mid;
        r_lo_start    <= n_lo_start;
        r_off         <= n_off;
        r_q           <= n_q;
        r_start       <= n_start;
        r_crlf        <= n_crlf;
        r_kind        <= n_kind;
        r_found       <= n_found;
        r_line_index  <= n_line_index;
        r_column      <= n_column;
        r_span_start  <= n_span_start;
        r_span_end    <= n_span_end;
        r_content_end <= n_content_end;
        r_ovf_out     <= n_ovf_out;
        if (ls_re) begin
            r_rd_zero <= (ls_ra == '0);
        end
    end

    assign o_valid       = r_valid;
    assign o_answer_kind = r_kind;
    assign o_found       = r_found;
    assign o_line_index  = r_line_index;
    assign o_column      = r_column;
    assign o_span_start  = r_span_start;
    assign o_span_end    = r_span_end;
    assign o_content_end = r_content_end;
    assign o_overflow    = r_ovf_out;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_line_count >= COUNT_BITS'(1)) && (r_line_count <= COUNT_BITS'(MAX_LINES)))
        else $error("Line count left its legal range.");

    a_probe_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOC_CMP) |-> (r_mid > r_lo) && (r_mid <= r_hi))
        else $error("Search probe outside the current window.");

    a_locate_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_answer_kind) |-> o_found)
        else $error("Locate answer without found.");

    a_missing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_span_start == '0) && (o_span_end == '0)
            && (o_content_end == '0))
        else $error("Missing line reported a nonzero span.");

    a_append_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_mode == MODE_APPEND)) |=> !busy && !o_valid)
        else $error("Append transaction did not finish in one cycle.");

endmodule

// ===== rtl/lot_ram.sv =====
module lot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_re) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== verif/line_offset_table_core_tb.sv =====
`timescale 1ns / 1ps

module line_offset_table_core_tb;
    import lot_pkg::*;

    typedef struct packed {
        logic                   kind;
        logic                   found;
        logic [LINE_BITS-1:0]   line;
        logic [OFFSET_BITS-1:0] col;
        logic [OFFSET_BITS-1:0] first;
        logic [OFFSET_BITS-1:0] last;
        logic [OFFSET_BITS-1:0] body_end;
        logic                   ovf;
    } t_answer;

    typedef struct packed {
        t_mode                  mode;
        logic [7:0]             data;
        logic [OFFSET_BITS-1:0] off;
        logic [LINE_BITS-1:0]   line;
        bit                     typed;
        t_answer                ans;
    } t_step_row;

    localparam t_answer ANS_NONE   = '0;
    localparam t_answer LOC_ORIGIN = '{1'b0, 1'b1, '0, '0, '0, '0, '0, 1'b0};
    localparam t_answer LOC_FAR    = '{1'b0, 1'b1, '0, OFFSET_MAX, '0, '0, '0, 1'b0};
    localparam t_answer SPAN_EMPTY = '{1'b1, 1'b1, '0, '0, '0, '0, '0, 1'b0};
    localparam t_answer SPAN_MISS  = '{1'b1, 1'b0, '0, '0, '0, '0, '0, 1'b0};

    localparam int DIR_ROWS   = 26;
    localparam int RAND_ITEMS = 480;
    localparam int FILL_BYTES = 1060;
    localparam int EXP_DEPTH  = 16;

    // Builds "a<CR><LF>b<CR><FF><LF><00>" so that a CRLF ending, a lone CR and a bare LF all
    // appear, then restarts the text with a leading LF.
    localparam t_step_row DIR_TAB [DIR_ROWS] = '{
        '{MODE_LOCATE, 8'h00, '0,         '0,    1'b1, LOC_ORIGIN},
        '{MODE_LOCATE, 8'h00, OFFSET_MAX, '0,    1'b1, LOC_FAR},
        '{MODE_SPAN,   8'h00, '0,         '0,    1'b1, SPAN_EMPTY},
        '{MODE_SPAN,   8'h00, '0,         10'd1, 1'b1, SPAN_MISS},
        '{MODE_SPAN,   8'h00, '0,         '1,    1'b1, SPAN_MISS},
        '{MODE_APPEND, 8'h61, '0,         '0,    1'b0, ANS_NONE},
        '{MODE_APPEND, CH_CR, '0,         '0,    1'b0, ANS_NONE},
        '{MODE_APPEND, CH_LF, '0,         '0,    1'b0, ANS_NONE},
        '{MODE_APPEND, 8'h62, '0,         '0,    1'b0, ANS_NONE},
        '{MODE_APPEND, CH_CR, '0,         '0,    1'b0, ANS_NONE},
        '{MODE_APPEND, 8'hFF, '0,         '0,    1'b0, ANS_NONE},
        '{MODE_APPEND, CH_LF, '0,         '0,    1'b0, ANS_NONE},
        '{MODE_APPEND, 8'h00, '0,         '0,    1'b0, ANS_NONE},
        '{MODE_SPAN,   8'h00, '0,         10'd0, 1'b0, ANS_NONE},
        '{MODE_SPAN,   8'h00, '0,         10'd1, 1'b0, ANS_NONE},
        '{MODE_SPAN,   8'h00, '0,         10'd2, 1'b0, ANS_NONE},
        '{MODE_SPAN,   8'h00, '0,         10'd3, 1'b1, SPAN_MISS},
        '{MODE_LOCATE, 8'h00, 20'd3,      '0,    1'b0, ANS_NONE},
        '{MODE_LOCATE, 8'h00, 20'd6,      '0,    1'b0, ANS_NONE},
        '{MODE_LOCATE, 8'h00, OFFSET_MAX, '0,    1'b0, ANS_NONE},
        '{MODE_NEW,    8'h00, '0,         '0,    1'b0, ANS_NONE},
        '{MODE_APPEND, CH_LF, '0,         '0,    1'b0, ANS_NONE},
        '{MODE_SPAN,   8'h00, '0,         10'd0, 1'b0, ANS_NONE},
        '{MODE_LOCATE, 8'h00, '0,         '0,    1'b1, LOC_ORIGIN},
        '{MODE_NEW,    8'h00, '0,         '0,    1'b0, ANS_NONE},
        '{MODE_SPAN,   8'h00, '0,         10'd1, 1'b1, SPAN_MISS}
    };

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic [1:0]             i_mode;
    logic [7:0]             i_data_byte;
    logic [OFFSET_BITS-1:0] i_query_offset;
    logic [LINE_BITS-1:0]   i_query_line;
    logic                   o_valid;
    logic                   o_answer_kind;
    logic                   o_found;
    logic [LINE_BITS-1:0]   o_line_index;
    logic [OFFSET_BITS-1:0] o_column;
    logic [OFFSET_BITS-1:0] o_span_start;
    logic [OFFSET_BITS-1:0] o_span_end;
    logic [OFFSET_BITS-1:0] o_content_end;
    logic                   o_overflow;

    logic [OFFSET_BITS-1:0] line_start [MAX_LINES];
    bit                     line_crlf [MAX_LINES];
    int unsigned            n_lines;
    int unsigned            text_len;
    bit                     last_cr;
    bit                     ovf_flag;

    t_answer     exp_mem [EXP_DEPTH];
    int unsigned exp_wr;
    int unsigned exp_rd;
    t_answer     want;
    t_answer     got;
    bit          idle_on;
    int          err_count;
    int          n_items;
    int          n_locate;
    int          n_span;
    int          n_checked;

    line_offset_table_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_data_byte    (i_data_byte),
        .i_query_offset (i_query_offset),
        .i_query_line   (i_query_line),
        .o_valid        (o_valid),
        .o_answer_kind  (o_answer_kind),
        .o_found        (o_found),
        .o_line_index   (o_line_index),
        .o_column       (o_column),
        .o_span_start   (o_span_start),
        .o_span_end     (o_span_end),
        .o_content_end  (o_content_end),
        .o_overflow     (o_overflow)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic bit predict_answer(input t_mode m, input logic [7:0] data,
                                          input logic [OFFSET_BITS-1:0] off,
                                          input logic [LINE_BITS-1:0] line,
                                          output t_answer a);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        a = '0;
        case (m)
            MODE_APPEND: begin
                if (text_len >= OFFSET_MAX) begin
                    ovf_flag = 1'b1;
                end else begin
                    text_len++;
                    if (data == CH_LF) begin
                        if (n_lines < MAX_LINES) begin
                            line_crlf[n_lines-1] = last_cr;
                            line_start[n_lines] = text_len[OFFSET_BITS-1:0];
                            n_lines++;
                        end else begin
                            ovf_flag = 1'b1;
                        end
                    end
                    last_cr = (data == CH_CR);
                end
                return 1'b0;
            end
            MODE_NEW: begin
                line_start[0] = '0;
                n_lines = 1;
                text_len = 0;
                last_cr = 1'b0;
                ovf_flag = 1'b0;
                return 1'b0;
            end
            MODE_LOCATE: begin
                lo = 0;
                hi = n_lines - 1;
                while (lo < hi) begin
                    mid = lo + (hi - lo + 1) / 2;
                    if (line_start[mid] <= off) lo = mid;
                    else hi = mid - 1;
                end
                a.found = 1'b1;
                a.line = lo[LINE_BITS-1:0];
                a.col = off - line_start[lo];
            end
            default: begin
                a.kind = 1'b1;
                if (line < n_lines) begin
                    a.found = 1'b1;
                    a.first = line_start[line];
                    if (line == n_lines - 1) begin
                        a.last = text_len[OFFSET_BITS-1:0];
                        a.body_end = text_len[OFFSET_BITS-1:0];
                    end else begin
                        a.last = line_start[line+1];
                        a.body_end = a.last - OFFSET_BITS'(line_crlf[line] ? 2 : 1);
                    end
                end
            end
        endcase
        a.ovf = ovf_flag;
        return 1'b1;
    endfunction

    task automatic send_item(input t_mode m, input logic [7:0] data,
                             input logic [OFFSET_BITS-1:0] off,
                             input logic [LINE_BITS-1:0] line,
                             input bit typed, input t_answer typed_ans);
        t_answer a;
        start <= 1'b1;
        i_mode <= m;
        i_data_byte <= data;
        i_query_offset <= off;
        i_query_line <= line;
        do @(posedge i_clk); while (busy);
        n_items++;
        if (predict_answer(m, data, off, line, a)) begin
            if (exp_wr - exp_rd >= EXP_DEPTH) begin
                err_count++;
                $display("%0t: too many answers outstanding", $time);
            end else begin
                exp_mem[exp_wr % EXP_DEPTH] = typed ? typed_ans : a;
                exp_wr++;
            end
            if (m == MODE_LOCATE) n_locate++;
            else n_span++;
        end
    endtask

    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic maybe_idle();
        if (idle_on && $urandom_range(0, 7) == 0) hold_off($urandom_range(1, 15));
    endtask

    task automatic send_locate(input logic [OFFSET_BITS-1:0] off);
        send_item(MODE_LOCATE, 8'h00, off, '0, 1'b0, ANS_NONE);
    endtask

    task automatic send_span(input logic [LINE_BITS-1:0] line);
        send_item(MODE_SPAN, 8'h00, '0, line, 1'b0, ANS_NONE);
    endtask

    task automatic send_byte(input logic [7:0] data);
        send_item(MODE_APPEND, data, '0, '0, 1'b0, ANS_NONE);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid !== 1'b0) begin
            got = '{o_answer_kind, o_found, o_line_index, o_column, o_span_start,
                    o_span_end, o_content_end, o_overflow};
            if (exp_wr == exp_rd) begin
                err_count++;
                $display("%0t: answer with none expected: kind=%0d found=%0d line=%0d col=%0d",
                         $time, got.kind, got.found, got.line, got.col);
            end else begin
                want = exp_mem[exp_rd % EXP_DEPTH];
                exp_rd++;
                n_checked++;
                if (got !== want) begin
                    err_count++;
                    if (err_count <= 40) begin
                        $display("%0t: answer mismatch", $time);
                        $display("  expected kind=%0d found=%0d line=%0d col=%0d start=%0d end=%0d cend=%0d ovf=%0d",
                                 want.kind, want.found, want.line, want.col, want.first,
                                 want.last, want.body_end, want.ovf);
                        $display("  actual   kind=%0d found=%0d line=%0d col=%0d start=%0d end=%0d cend=%0d ovf=%0d",
                                 got.kind, got.found, got.line, got.col, got.first,
                                 got.last, got.body_end, got.ovf);
                    end
                end
            end
        end
    end

    initial begin
        int          ep_len;
        int          lf_div;
        int          r;
        int          waited;
        logic [7:0]  data;
        logic [31:0] rnd;
        err_count = 0;
        n_items = 0;
        n_locate = 0;
        n_span = 0;
        n_checked = 0;
        exp_wr = 0;
        exp_rd = 0;
        idle_on = 1'b1;
        line_start[0] = '0;
        n_lines = 1;
        text_len = 0;
        last_cr = 1'b0;
        ovf_flag = 1'b0;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_mode <= MODE_APPEND;
        i_data_byte <= '0;
        i_query_offset <= '0;
        i_query_line <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            send_item(DIR_TAB[i].mode, DIR_TAB[i].data, DIR_TAB[i].off, DIR_TAB[i].line,
                      DIR_TAB[i].typed, DIR_TAB[i].ans);
            maybe_idle();
        end

        // Each episode is a fresh text with its own density of line endings, queried as it grows.
        while (n_items < DIR_ROWS + RAND_ITEMS) begin
            ep_len = $urandom_range(10, 250);
            lf_div = $urandom_range(2, 24);
            idle_on = ($urandom_range(0, 2) != 0);
            send_item(MODE_NEW, 8'($urandom), 20'($urandom), 10'($urandom), 1'b0, ANS_NONE);
            for (int k = 0; k < ep_len; k++) begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    if ($urandom_range(0, lf_div - 1) == 0) data = CH_LF;
                    else if ($urandom_range(0, 5) == 0) data = CH_CR;
                    else data = 8'($urandom);
                    send_byte(data);
                end else if (r < 78) begin
                    if ($urandom_range(0, 9) == 0) rnd = $urandom;
                    else rnd = $urandom_range(0, text_len + 4);
                    send_locate(rnd[OFFSET_BITS-1:0]);
                end else if (r < 96) begin
                    if ($urandom_range(0, 9) == 0) rnd = $urandom;
                    else rnd = $urandom_range(0, n_lines + 1);
                    send_span(rnd[LINE_BITS-1:0]);
                end else if (r < 98) begin
                    send_item(MODE_NEW, 8'h00, '0, '0, 1'b0, ANS_NONE);
                end else begin
                    send_item(t_mode'($urandom_range(0, 3)), 8'($urandom), 20'($urandom),
                              10'($urandom), 1'b0, ANS_NONE);
                end
                maybe_idle();
            end
        end

        // Fill the line table past its last entry.
        idle_on = 1'b1;
        send_item(MODE_NEW, 8'h00, '0, '0, 1'b0, ANS_NONE);
        for (int k = 0; k < FILL_BYTES; k++) begin
            if (k % 64 != 63) data = CH_LF;
            else if (k[6]) data = CH_CR;
            else data = 8'($urandom);
            send_byte(data);
            maybe_idle();
        end

        idle_on = 1'b0;
        for (int k = 0; k < 40; k++) begin
            if (k[0]) send_span(10'($urandom_range(MAX_LINES - 12, MAX_LINES - 1)));
            else send_locate(20'($urandom_range(0, text_len + 2)));
        end
        send_span(LINE_BITS'(MAX_LINES - 1));
        send_locate(OFFSET_MAX);
        send_span(10'(n_lines - 1));
        send_span(10'(n_lines));
        send_span(10'd0);
        for (int k = 0; k < 12; k++) begin
            if (k[0]) send_locate(20'($urandom));
            else send_span(10'($urandom_range(0, n_lines)));
        end

        start <= 1'b0;
        waited = 0;
        while (exp_wr != exp_rd && waited < 1000) begin
            @(posedge i_clk);
            waited++;
        end
        if (exp_wr != exp_rd) begin
            err_count++;
            $display("%0t: %0d answers never arrived", $time, exp_wr - exp_rd);
        end
        repeat (2 * LINE_BITS + 8) @(posedge i_clk);

        $display("Sent %0d transactions and checked %0d answers (%0d locate, %0d span).",
                 n_items, n_checked, n_locate, n_span);
        $display("Texts covered CRLF and bare LF endings, lone CRs and a full line table.");
        if (err_count == 0)
            $display("line_offset_table_core_tb: clean");
        else
            $display("line_offset_table_core_tb: errors");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("line_offset_table_core_tb: errors");
        $finish;
    end

endmodule
